// ----- hdl/ifr_pkg.sv -----
// ----------------------------------------------------------------------------
// ifr_pkg
// Types and constants shared by the information frame receiver files.
// ----------------------------------------------------------------------------
`default_nettype none

package ifr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [BYTE_W-1:0] START_CODE_LO = 8'h00;
	localparam logic [BYTE_W-1:0] START_CODE_HI = 8'hFF;
	localparam logic [BYTE_W-1:0] PREV_BYTE_RST = 8'hFF;
	localparam logic [BYTE_W-1:0] CAPACITY_RST  = 8'd32;
	localparam logic [BYTE_W-1:0] SCAN_LIM_RST  = 8'd25;

	typedef enum logic [0:0] {
		KIND_BEGIN = 1'b0,
		KIND_BYTE  = 1'b1
	} item_kind_t;

	typedef enum logic [1:0] {
		RK_PAYLOAD  = 2'd0,
		RK_DONE     = 2'd1,
		RK_NOSTART  = 2'd2,
		RK_LENCHECK = 2'd3
	} res_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUFFER_CAPACITY  = 1'b0,
		REG_START_SCAN_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SCAN = 3'd1,
		PH_LEN  = 3'd2,
		PH_LCS  = 3'd3,
		PH_DATA = 3'd4,
		PH_DCS  = 3'd5,
		PH_POST = 3'd6,
		PH_DONE = 3'd7
	} phase_t;

endpackage

`default_nettype wire

// ----- hdl/ifr_if.sv -----
// ----------------------------------------------------------------------------
// ifr_if
// Handshake channels of the information frame receiver: received bytes in,
// results out, and the register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifr_in_if;
	logic                valid;
	logic                ready;
	ifr_pkg::item_kind_t kind;
	logic [7:0]          rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);
	modport mon    (input valid, input kind, input rx_byte, input ready);
endinterface

interface ifr_out_if;
	logic               valid;
	logic               ready;
	ifr_pkg::res_kind_t result_kind;
	logic [7:0]         payload_byte;
	logic [7:0]         payload_index;
	logic [7:0]         payload_count;

	modport source (output valid, output result_kind, output payload_byte,
		output payload_index, output payload_count, input ready);
	modport sink   (input valid, input result_kind, input payload_byte,
		input payload_index, input payload_count, output ready);
	modport mon    (input valid, input result_kind, input payload_byte,
		input payload_index, input payload_count, input ready);
endinterface

interface ifr_cfg_if;
	logic              valid;
	logic              ready;
	ifr_pkg::cfg_reg_t reg_index;
	logic [7:0]        wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
	modport mon    (input valid, input reg_index, input wr_data, input ready);
endinterface

`default_nettype wire

// ----- hdl/info_frame_receiver_unit.sv -----
// Results are registered: an accepted byte loads the input register, and its
// result loads the result register when the input stage advances.
// Throughput: one transaction per cycle on the input; a stalled result
// holds the byte in the input register and drops ready only then.
// Reset (arst_n low): phase idle, previous byte FF, counters zero, capacity
// 32, scan limit 25, both pipeline stages empty.
// ----------------------------------------------------------------------------
// info_frame_receiver_unit
// Parses a response frame: start code scan, length check, payload bytes up
// to the buffer capacity, and a done report after the postamble.
// ----------------------------------------------------------------------------
`default_nettype none

module info_frame_receiver_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ifr_in_if.sink     req,
	ifr_out_if.source  rsp,
	ifr_cfg_if.sink    cfg
);
	import ifr_pkg::*;

	// configuration
	logic [BYTE_W-1:0] capacity_q;
	logic [BYTE_W-1:0] scan_limit_q;

	// input stage
	logic              valid_s1;
	item_kind_t        kind_s1;
	logic [BYTE_W-1:0] byte_s1;

	// frame state
	phase_t            phase_q,    phase_d;
	logic [BYTE_W-1:0] prev_q,     prev_d;
	logic [BYTE_W-1:0] scan_cnt_q, scan_cnt_d;
	logic [BYTE_W-1:0] len_q,      len_d;
	logic [BYTE_W-1:0] pos_q,      pos_d;
	logic [BYTE_W-1:0] kept_q,     kept_d;

	// result stage
	logic              valid_s2;
	res_kind_t         kind_s2;
	logic [BYTE_W-1:0] pbyte_s2;
	logic [BYTE_W-1:0] pidx_s2;
	logic [BYTE_W-1:0] pcnt_s2;

	logic              res_hit;
	res_kind_t         res_kind;
	logic [BYTE_W-1:0] res_pbyte;
	logic [BYTE_W-1:0] res_pidx;
	logic [BYTE_W-1:0] res_pcnt;

	logic              adv;
	logic              in_ready;
	logic [BYTE_W-1:0] scan_inc;
	logic [BYTE_W-1:0] pos_inc;
	logic              start_hit;
	logic              keep_byte;

	assign adv      = valid_s1 && (!valid_s2 || rsp.ready);
	assign in_ready = !valid_s1 || adv;
	assign req.ready = in_ready;
	assign cfg.ready = 1'b1;

	assign scan_inc  = scan_cnt_q + 1'b1;
	assign pos_inc   = pos_q + 1'b1;
	assign start_hit = (prev_q == START_CODE_LO) && (byte_s1 == START_CODE_HI);
	assign keep_byte = pos_q < capacity_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q   <= CAPACITY_RST;
			scan_limit_q <= SCAN_LIM_RST;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				REG_BUFFER_CAPACITY:  capacity_q   <= cfg.wr_data;
				REG_START_SCAN_LIMIT: scan_limit_q <= cfg.wr_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && req.valid) begin
			kind_s1 <= req.kind;
			byte_s1 <= req.rx_byte;
		end
	end

	// next frame state
	always_comb begin
		phase_d    = phase_q;
		prev_d     = prev_q;
		scan_cnt_d = scan_cnt_q;
		len_d      = len_q;
		pos_d      = pos_q;
		kept_d     = kept_q;
		if (adv) begin
			if (kind_s1 == KIND_BEGIN) begin
				phase_d    = PH_SCAN;
				prev_d     = PREV_BYTE_RST;
				scan_cnt_d = '0;
				len_d      = '0;
				pos_d      = '0;
				kept_d     = '0;
			end else begin
				unique case (phase_q)
					PH_SCAN: begin
						scan_cnt_d = scan_inc;
						if (start_hit) begin
							phase_d = PH_LEN;
						end else begin
							prev_d = byte_s1;
							if (scan_inc >= scan_limit_q)
								phase_d = PH_DONE;
						end
					end
					PH_LEN: begin
						len_d   = byte_s1;
						phase_d = PH_LCS;
					end
					PH_LCS: begin
						if (BYTE_W'(len_q + byte_s1) != '0) begin
							phase_d = PH_DONE;
						end else begin
							pos_d   = '0;
							kept_d  = '0;
							phase_d = (len_q == '0) ? PH_DCS : PH_DATA;
						end
					end
					PH_DATA: begin
						if (keep_byte)
							kept_d = kept_q + 1'b1;
						pos_d = pos_inc;
						if (pos_inc == len_q)
							phase_d = PH_DCS;
					end
					PH_DCS:  phase_d = PH_POST;
					PH_POST: phase_d = PH_DONE;
					PH_IDLE, PH_DONE: ;
				endcase
			end
		end
	end

	// result of the byte in the input stage
	always_comb begin
		res_hit   = 1'b0;
		res_kind  = RK_PAYLOAD;
		res_pbyte = '0;
		res_pidx  = '0;
		res_pcnt  = '0;
		if (kind_s1 == KIND_BYTE) begin
			unique case (phase_q)
				PH_SCAN: begin
					if (!start_hit && scan_inc >= scan_limit_q) begin
						res_hit  = 1'b1;
						res_kind = RK_NOSTART;
					end
				end
				PH_LCS: begin
					if (BYTE_W'(len_q + byte_s1) != '0) begin
						res_hit  = 1'b1;
						res_kind = RK_LENCHECK;
					end
				end
				PH_DATA: begin
					if (keep_byte) begin
						res_hit   = 1'b1;
						res_kind  = RK_PAYLOAD;
						res_pbyte = byte_s1;
						res_pidx  = pos_q;
					end
				end
				PH_POST: begin
					res_hit  = 1'b1;
					res_kind = RK_DONE;
					res_pcnt = kept_q;
				end
				PH_IDLE, PH_LEN, PH_DCS, PH_DONE: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			prev_q     <= PREV_BYTE_RST;
			scan_cnt_q <= '0;
			len_q      <= '0;
			pos_q      <= '0;
			kept_q     <= '0;
		end else begin
			phase_q    <= phase_d;
			prev_q     <= prev_d;
			scan_cnt_q <= scan_cnt_d;
			len_q      <= len_d;
			pos_q      <= pos_d;
			kept_q     <= kept_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= res_hit;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_hit) begin
			kind_s2  <= res_kind;
			pbyte_s2 <= res_pbyte;
			pidx_s2  <= res_pidx;
			pcnt_s2  <= res_pcnt;
		end
	end

	assign rsp.valid         = valid_s2;
	assign rsp.result_kind   = kind_s2;
	assign rsp.payload_byte  = pbyte_s2;
	assign rsp.payload_index = pidx_s2;
	assign rsp.payload_count = pcnt_s2;

endmodule

`default_nettype wire

// ----- hdl/ifr_checker.sv -----
// ----------------------------------------------------------------------------
// ifr_checker
// Port-level checks on the information frame receiver, bound to info_frame_receiver_unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ifr_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_ready,
	input wire logic               rsp_valid,
	input wire logic               rsp_ready,
	input wire ifr_pkg::res_kind_t rsp_result_kind,
	input wire logic [7:0]         rsp_payload_byte,
	input wire logic [7:0]         rsp_payload_index,
	input wire logic [7:0]         rsp_payload_count,
	input wire logic               cfg_ready
);
	import ifr_pkg::*;

	// the input only stalls behind a result that is itself stalled
	ast_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (rsp_valid && !rsp_ready))
		else $error("input stalled without a stalled result");

	// hold a stalled result
	ast_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_kind)
			&& $stable(rsp_payload_byte) && $stable(rsp_payload_index)
			&& $stable(rsp_payload_count)))
		else $error("stalled result changed");

	ast_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_result_kind != RK_PAYLOAD)
			|-> (rsp_payload_byte == '0 && rsp_payload_index == '0))
		else $error("status result carries payload fields");

	ast_count_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_result_kind != RK_DONE) |-> (rsp_payload_count == '0))
		else $error("count present on a result other than frame done");

	ast_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("register write channel stalled");

endmodule

bind info_frame_receiver_unit ifr_checker u_ifr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_result_kind   (rsp.result_kind),
	.rsp_payload_byte  (rsp.payload_byte),
	.rsp_payload_index (rsp.payload_index),
	.rsp_payload_count (rsp.payload_count),
	.cfg_ready         (cfg.ready)
);

`default_nettype wire
